[rtl/core/lcd_command_data_pixel_writer_unit_macros.svh]
// Assertion helpers for the LCD pixel writer.
`ifndef LCD_COMMAND_DATA_PIXEL_WRITER_UNIT_MACROS_SVH
`define LCD_COMMAND_DATA_PIXEL_WRITER_UNIT_MACROS_SVH

// Checked property, masked while reset is held.
`define LCDPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked property, live during reset as well.
`define LCDPW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/lcdpw_pkg.sv]
package lcdpw_pkg;

    // Screen geometry
    localparam int WIDTH_PIXELS  = 128;
    localparam int HEIGHT_PIXELS = 128;

    localparam int COL_W = (WIDTH_PIXELS  > 1) ? $clog2(WIDTH_PIXELS)  : 1;
    localparam int ROW_W = (HEIGHT_PIXELS > 1) ? $clog2(HEIGHT_PIXELS) : 1;

    typedef logic [COL_W-1:0] t_col_cnt;
    typedef logic [ROW_W-1:0] t_row_cnt;
    typedef logic [6:0]       t_coord;
    typedef logic [7:0]       t_byte;
    typedef logic [3:0]       t_nibble;

    localparam t_col_cnt COL_LAST = t_col_cnt'(WIDTH_PIXELS - 1);
    localparam t_row_cnt ROW_LAST = t_row_cnt'(HEIGHT_PIXELS - 1);

    // Bus operation codes
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_DATA    = 1'b1;

    // Command codes
    localparam t_byte CMD_PAGE_SET   = 8'h75;
    localparam t_byte CMD_COLUMN_SET = 8'h15;
    localparam t_byte CMD_NORMAL     = 8'hA6;
    localparam t_byte CMD_INVERSE    = 8'hA7;
    localparam t_byte CMD_MEM_WRITE  = 8'h5C;

    // Nibble times 17 is the nibble repeated; normal display shows 255 minus that.
    function automatic t_byte expand_channel(input t_nibble nib, input logic inverse);
        t_byte v;
        v = {nib, nib};
        return inverse ? v : ~v;
    endfunction

endpackage

[rtl/core/lcdpw_if.sv]
// Bus byte channel
interface lcdpw_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// Pixel result channel
interface lcdpw_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] column;
    logic [6:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output column, output row, output red,
                    output green, output blue, input ready);
    modport sink   (input valid, input column, input row, input red,
                    input green, input blue, output ready);
endinterface

[rtl/core/lcd_command_data_pixel_writer_unit.sv]
// LCD command/data bus pixel writer. Takes one bus item per cycle on i_in
// (operation 0 = command byte, 1 = data byte) and emits one pixel item on
// o_out for every completed pair of data bytes received while the latched
// command is memory write (0x5C). The first byte of a pair gives red in its
// low nibble, the second gives green (high nibble) and blue (low nibble);
// each nibble is widened to 8 bits by repetition and shown as 255 minus
// that value in normal display (0xA6) or as is in inverse display (0xA7).
// Page-set (0x75) and column-set (0x15) send the write position back to the
// origin; the position otherwise steps in raster order and wraps at the end
// of the screen. Commands never reset the pairing phase. Rate: one item per
// cycle sustained unless the output stalls. A bus item sits in the input
// register after its accepting edge; when the input stage retires it, the
// controller state is updated and any completed pixel is loaded into the
// result register, from which it is offered. The input stage only holds
// while a pixel is ready to leave it and the result register is still full
// and unclaimed, so i_in.ready drops only under output back-pressure.
module lcd_command_data_pixel_writer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcdpw_in_if.sink      i_in,
    lcdpw_out_if.source   o_out
);

    // Input register
    logic                r_s1_valid;
    logic                r_s1_op;
    lcdpw_pkg::t_byte    r_s1_value;

    // Controller state
    lcdpw_pkg::t_byte    r_last_cmd,   n_last_cmd;
    logic                r_expect_red, n_expect_red;
    lcdpw_pkg::t_nibble  r_red_nib,    n_red_nib;
    logic                r_inverse,    n_inverse;
    lcdpw_pkg::t_col_cnt r_col,        n_col;
    lcdpw_pkg::t_row_cnt r_row,        n_row;

    // Result register
    logic                r_out_valid;
    lcdpw_pkg::t_coord   r_out_column;
    lcdpw_pkg::t_coord   r_out_row;
    lcdpw_pkg::t_byte    r_out_red;
    lcdpw_pkg::t_byte    r_out_green;
    lcdpw_pkg::t_byte    r_out_blue;

    logic s1_mem_data;   // data byte under memory write
    logic s1_emit;       // item completes a pixel
    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign s1_mem_data = r_s1_valid && (r_s1_op == lcdpw_pkg::OP_DATA)
                         && (r_last_cmd == lcdpw_pkg::CMD_MEM_WRITE);
    assign s1_emit     = s1_mem_data && !r_expect_red;
    assign out_free    = !r_out_valid || o_out.ready;
    // Items with no pixel never wait on the output side.
    assign s1_fire     = r_s1_valid && (!s1_emit || out_free);
    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign in_fire     = i_in.valid && i_in.ready;

    // Next controller state, applied when the input stage retires its item
    always_comb begin
        n_last_cmd   = r_last_cmd;
        n_expect_red = r_expect_red;
        n_red_nib    = r_red_nib;
        n_inverse    = r_inverse;
        n_col        = r_col;
        n_row        = r_row;
        if (r_s1_valid && (r_s1_op == lcdpw_pkg::OP_COMMAND)) begin
            n_last_cmd = r_s1_value;
            priority if (r_s1_value == lcdpw_pkg::CMD_PAGE_SET ||
                         r_s1_value == lcdpw_pkg::CMD_COLUMN_SET) begin
                n_col = '0;
                n_row = '0;
            end else if (r_s1_value == lcdpw_pkg::CMD_NORMAL) begin
                n_inverse = 1'b0;
            end else if (r_s1_value == lcdpw_pkg::CMD_INVERSE) begin
                n_inverse = 1'b1;
            end else begin
                // other commands are only latched
            end
        end else if (s1_mem_data) begin
            if (r_expect_red) begin
                n_red_nib    = r_s1_value[3:0];
                n_expect_red = 1'b0;
            end else begin
                n_expect_red = 1'b1;
                // raster step, wrap at end of line and of screen
                if (r_col == lcdpw_pkg::COL_LAST) begin
                    n_col = '0;
                    n_row = (r_row == lcdpw_pkg::ROW_LAST) ? '0 : r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_last_cmd   <= '0;
            r_expect_red <= 1'b1;
            r_red_nib    <= '0;
            r_inverse    <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_last_cmd   <= n_last_cmd;
                r_expect_red <= n_expect_red;
                r_red_nib    <= n_red_nib;
                r_inverse    <= n_inverse;
                r_col        <= n_col;
                r_row        <= n_row;
            end
        end
    end

    // Input payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op    <= i_in.operation;
            r_s1_value <= i_in.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_emit) begin
            r_out_column <= lcdpw_pkg::t_coord'(r_col);
            r_out_row    <= lcdpw_pkg::t_coord'(r_row);
            r_out_red    <= lcdpw_pkg::expand_channel(r_red_nib, r_inverse);
            r_out_green  <= lcdpw_pkg::expand_channel(r_s1_value[7:4], r_inverse);
            r_out_blue   <= lcdpw_pkg::expand_channel(r_s1_value[3:0], r_inverse);
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.column = r_out_column;
    assign o_out.row    = r_out_row;
    assign o_out.red    = r_out_red;
    assign o_out.green  = r_out_green;
    assign o_out.blue   = r_out_blue;

`include "lcd_command_data_pixel_writer_unit_macros.svh"

    `LCDPW_ASSERT(a_col_in_range, (r_col <= lcdpw_pkg::COL_LAST), "column past width")
    `LCDPW_ASSERT(a_row_in_range, (r_row <= lcdpw_pkg::ROW_LAST), "row past height")
    `LCDPW_ASSERT(a_emit_loads_out,
                  (s1_fire && s1_emit) |=> (r_out_valid && r_expect_red),
                  "pixel not registered or pairing phase not restored")
    `LCDPW_ASSERT(a_no_overwrite,
                  (r_out_valid && !o_out.ready) |-> !(s1_fire && s1_emit),
                  "pending pixel overwritten")
    `LCDPW_ASSERT_RST(a_reset_clears,
                      !i_rst_n |=> (!r_out_valid && !r_s1_valid && r_expect_red),
                      "reset did not clear control state")

endmodule

[test/lcd_command_data_pixel_writer_unit_tb.sv]
`timescale 1ns / 1ps

module lcd_command_data_pixel_writer_unit_tb;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 150;
    localparam int MAX_REPORTS   = 200;

    // Predicts the pixel stream from the accepted bus items and checks it.
    class pixel_scoreboard;
        typedef struct packed {
            lcdpw_pkg::t_coord col;
            lcdpw_pkg::t_coord row;
            lcdpw_pkg::t_byte  red;
            lcdpw_pkg::t_byte  green;
            lcdpw_pkg::t_byte  blue;
        } t_pixel;

        t_pixel             pixel_q[$];
        lcdpw_pkg::t_byte   cmd_latch;
        bit                 want_red;
        lcdpw_pkg::t_nibble held_red;
        bit                 inverse;
        int unsigned        col_pos;
        int unsigned        row_pos;
        int                 errors;

        function new();
            cmd_latch = '0;
            want_red  = 1'b1;
            held_red  = '0;
            inverse   = 1'b0;
            col_pos   = 0;
            row_pos   = 0;
            errors    = 0;
        endfunction

        function lcdpw_pkg::t_byte shade(lcdpw_pkg::t_nibble nib);
            int unsigned v;
            v = nib * 17;
            if (!inverse) begin
                v = 255 - v;
            end
            return lcdpw_pkg::t_byte'(v);
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function void note_input(logic op, lcdpw_pkg::t_byte v);
            t_pixel px;
            if (op == lcdpw_pkg::OP_COMMAND) begin
                cmd_latch = v;
                if (v == lcdpw_pkg::CMD_PAGE_SET || v == lcdpw_pkg::CMD_COLUMN_SET) begin
                    col_pos = 0;
                    row_pos = 0;
                end else if (v == lcdpw_pkg::CMD_NORMAL) begin
                    inverse = 1'b0;
                end else if (v == lcdpw_pkg::CMD_INVERSE) begin
                    inverse = 1'b1;
                end
                return;
            end
            if (cmd_latch != lcdpw_pkg::CMD_MEM_WRITE) begin
                return;
            end
            if (want_red) begin
                held_red = v[3:0];
                want_red = 1'b0;
                return;
            end
            want_red = 1'b1;
            px.col   = lcdpw_pkg::t_coord'(col_pos);
            px.row   = lcdpw_pkg::t_coord'(row_pos);
            px.red   = shade(held_red);
            px.green = shade(v[7:4]);
            px.blue  = shade(v[3:0]);
            pixel_q.push_back(px);
            col_pos++;
            if (col_pos >= lcdpw_pkg::WIDTH_PIXELS) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= lcdpw_pkg::HEIGHT_PIXELS) begin
                    row_pos = 0;
                end
            end
        endfunction

        function void field_check(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                end
            end
        endfunction

        function void check_result(lcdpw_pkg::t_coord col, lcdpw_pkg::t_coord row,
                                   lcdpw_pkg::t_byte r, lcdpw_pkg::t_byte g,
                                   lcdpw_pkg::t_byte b);
            t_pixel px;
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $error("pixel (%0d,%0d) with none expected", col, row);
                end
                return;
            end
            px = pixel_q.pop_front();
            field_check("column", px.col, col);
            field_check("row", px.row, row);
            field_check("red", px.red, r);
            field_check("green", px.green, g);
            field_check("blue", px.blue, b);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lcdpw_in_if  bus_if ();
    lcdpw_out_if pix_if ();

    lcd_command_data_pixel_writer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bus_if),
        .o_out   (pix_if)
    );

    pixel_scoreboard sb = new();

    int               burst_left = 0;
    int               gap_max    = 8;
    lcdpw_pkg::t_byte gen_cmd    = '0;
    int               useful_items = 0;
    int               stall_mode = 0;
    int               stall_left = 0;
    int               idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure: modes of varying duty, switched at random
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(40, 160);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                pix_if.ready = 1'b1;
            end
            1: begin
                pix_if.ready = ($urandom_range(0, 99) < 60);
            end
            2: begin
                pix_if.ready = ($urandom_range(0, 5) == 0);
            end
            default: begin
                pix_if.ready = ~pix_if.ready;
            end
        endcase
    end

    // Handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (bus_if.valid && bus_if.ready) begin
                sb.note_input(bus_if.operation, bus_if.value);
            end
            if (pix_if.valid && pix_if.ready) begin
                sb.check_result(pix_if.column, pix_if.row, pix_if.red, pix_if.green,
                                pix_if.blue);
            end
            if ((bus_if.valid && bus_if.ready) || (pix_if.valid && pix_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL lcd_command_data_pixel_writer_unit");
                $finish;
            end
        end
    end

    // Drive one bus item; entered and left at a falling edge
    task automatic put_item(logic op, lcdpw_pkg::t_byte v);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                bus_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        if (op == lcdpw_pkg::OP_COMMAND) begin
            gen_cmd = v;
            useful_items++;
        end else if (gen_cmd == lcdpw_pkg::CMD_MEM_WRITE) begin
            useful_items++;
        end
        bus_if.valid     = 1'b1;
        bus_if.operation = op;
        bus_if.value     = v;
        do begin
            @(posedge i_clk);
        end while (!bus_if.ready);
        @(negedge i_clk);
    endtask

    task automatic put_mode_cmd();
        put_item(lcdpw_pkg::OP_COMMAND,
                 ($urandom_range(0, 1) == 1) ? lcdpw_pkg::CMD_INVERSE : lcdpw_pkg::CMD_NORMAL);
    endtask

    task automatic put_data();
        put_item(lcdpw_pkg::OP_DATA, lcdpw_pkg::t_byte'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        bus_if.valid = 1'b0;
        while (sb.pending() > 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int               npairs;
        int               choice;
        lcdpw_pkg::t_byte other;
        i_rst_n          = 1'b0;
        bus_if.valid     = 1'b0;
        bus_if.operation = lcdpw_pkg::OP_COMMAND;
        bus_if.value     = '0;
        pix_if.ready     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: dropped data, both displays, extremes, straddled pair, origin resets
        put_item(lcdpw_pkg::OP_DATA, 8'h00);
        put_item(lcdpw_pkg::OP_DATA, 8'hFF);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
        put_item(lcdpw_pkg::OP_DATA, 8'h00);
        put_item(lcdpw_pkg::OP_DATA, 8'h00);
        put_item(lcdpw_pkg::OP_DATA, 8'hFF);
        put_item(lcdpw_pkg::OP_DATA, 8'hFF);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_INVERSE);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
        put_item(lcdpw_pkg::OP_DATA, 8'h0F);
        put_item(lcdpw_pkg::OP_DATA, 8'hF0);
        put_item(lcdpw_pkg::OP_DATA, 8'h35);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_NORMAL);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
        put_item(lcdpw_pkg::OP_DATA, 8'h9C);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_PAGE_SET);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
        put_item(lcdpw_pkg::OP_DATA, 8'hA1);
        put_item(lcdpw_pkg::OP_DATA, 8'h3E);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_COLUMN_SET);
        put_item(lcdpw_pkg::OP_DATA, 8'h12);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
        put_item(lcdpw_pkg::OP_DATA, 8'h80);
        put_item(lcdpw_pkg::OP_DATA, 8'h7F);
        put_item(lcdpw_pkg::OP_COMMAND, 8'hFF);
        put_item(lcdpw_pkg::OP_DATA, 8'h55);
        put_item(lcdpw_pkg::OP_COMMAND, 8'h00);

        // Random: mostly well-formed write bursts, some noise and broken sequences
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 75) begin
                if ($urandom_range(0, 1) == 1) begin
                    put_mode_cmd();
                end
                if ($urandom_range(0, 3) == 0) begin
                    put_item(lcdpw_pkg::OP_COMMAND,
                             ($urandom_range(0, 1) == 1) ? lcdpw_pkg::CMD_PAGE_SET
                                                         : lcdpw_pkg::CMD_COLUMN_SET);
                end
                put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
                npairs = $urandom_range(1, 24);
                repeat (npairs) begin
                    put_data();
                    if ($urandom_range(0, 9) == 0) begin
                        put_mode_cmd();
                        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
                    end
                    put_data();
                end
                if ($urandom_range(0, 4) == 0) begin
                    put_data();
                end
            end else if (choice < 90) begin
                put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::t_byte'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 4)) begin
                    put_data();
                end
            end else begin
                put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
                put_data();
                do begin
                    other = lcdpw_pkg::t_byte'($urandom_range(0, 255));
                end while (other == lcdpw_pkg::CMD_MEM_WRITE);
                put_item(lcdpw_pkg::OP_COMMAND, other);
                repeat ($urandom_range(1, 3)) begin
                    put_data();
                end
            end
        end

        // Hold the sender until every pixel is out
        wait_drained();

        // One full line plus a few pixels from the origin, so the column wraps
        gap_max = 2;
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_PAGE_SET);
        put_item(lcdpw_pkg::OP_COMMAND, lcdpw_pkg::CMD_MEM_WRITE);
        if (!sb.want_red) begin
            put_data();
        end
        repeat (lcdpw_pkg::WIDTH_PIXELS + 4) begin
            put_data();
            put_data();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS lcd_command_data_pixel_writer_unit");
        end else begin
            $display("FAIL lcd_command_data_pixel_writer_unit");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lcdpw_pkg.sv
rtl/core/lcdpw_if.sv
rtl/core/lcd_command_data_pixel_writer_unit.sv
test/lcd_command_data_pixel_writer_unit_tb.sv
